// ----- design/bbsf_pkg.sv -----
// Shared constants and types for the brace-balanced statement framer.
`default_nettype none
package bbsf_pkg;

	localparam int DEPTH_BITS = 8;

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	typedef enum logic [1:0] {
		END_CONTINUE = 2'd0,
		END_COMPLETE = 2'd1,
		END_DISCARD  = 2'd2
	} end_kind_t;

	typedef logic signed [DEPTH_BITS-1:0] depth_t;

	localparam depth_t DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
	localparam depth_t DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};

endpackage
`default_nettype wire

// ----- design/brace_balanced_statement_framer.sv -----
// Top level of the brace-balanced statement framer.
//
//  Channel | Handshake                 | Payload
//  --------+---------------------------+------------------------------------
//  input   | in_valid / in_ready       | in_byte, end_of_stream
//  output  | out_valid / out_ready     | out_byte, has_byte, end_kind
//
// One item is taken per cycle while in_ready is high; an item that yields a
// result has it registered into the output register as it is accepted, and
// the parser state is updated in the same cycle, so the next item may follow
// right away. in_ready is low only while a result waits in the output register
// and out_ready is low. arst_n clears parser state and empties output register.
`default_nettype none
module brace_balanced_statement_framer import bbsf_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_stream,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            has_byte,
	output logic [1:0]      end_kind
);

	depth_t depth_q;
	logic   str_q, esc_q, seen_q, cmt_q;

	depth_t    depth_nx;
	logic      str_nx, esc_nx, seen_nx, cmt_nx;
	logic      res_vld, res_has, clr;
	logic [7:0] res_byte;
	end_kind_t res_kind;
	logic      depth_zero, in_acc;

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       has_byte_q;
	end_kind_t  end_kind_q;

	assign depth_zero = (depth_q == '0);
	assign in_ready   = !out_valid_q || out_ready;
	assign in_acc     = in_valid && in_ready;

	always_comb begin
		depth_nx = depth_q;
		str_nx   = str_q;
		esc_nx   = esc_q;
		seen_nx  = seen_q;
		cmt_nx   = cmt_q;
		res_vld  = 1'b0;
		res_byte = in_byte;
		res_has  = 1'b1;
		res_kind = END_CONTINUE;
		clr      = 1'b0;
		priority if (end_of_stream) begin
			res_vld  = 1'b1;
			res_byte = 8'h00;
			res_has  = 1'b0;
			clr      = 1'b1;
			priority if (cmt_q && seen_q && depth_zero) begin
				res_byte = CH_NL;
				res_has  = 1'b1;
				res_kind = END_COMPLETE;
			end else if (seen_q && depth_zero && !str_q) begin
				res_kind = END_COMPLETE;
			end else begin
				res_kind = END_DISCARD;
			end
		end else if (cmt_q) begin
			// Comment bytes are dropped; the closing newline may end the statement.
			if (in_byte == CH_NL) begin
				cmt_nx = 1'b0;
				if (seen_q && depth_zero) begin
					res_vld  = 1'b1;
					res_kind = END_COMPLETE;
					clr      = 1'b1;
				end
			end
		end else begin
			res_vld = 1'b1;
			priority if (esc_q) begin
				esc_nx = 1'b0;
			end else if (str_q) begin
				if (in_byte == CH_BSLASH) begin
					esc_nx = 1'b1;
				end else if (in_byte == CH_QUOTE) begin
					str_nx = 1'b0;
				end
			end else if (in_byte == CH_QUOTE) begin
				str_nx  = 1'b1;
				seen_nx = 1'b1;
			end else if (in_byte == CH_LBRACE) begin
				if (depth_q != DEPTH_MAX) begin
					depth_nx = depth_q + depth_t'(1);
				end
				seen_nx = 1'b1;
			end else if (in_byte == CH_RBRACE) begin
				if (depth_q != DEPTH_MIN) begin
					depth_nx = depth_q - depth_t'(1);
				end
				seen_nx = 1'b1;
			end else if (in_byte == CH_HASH) begin
				cmt_nx  = 1'b1;
				res_vld = 1'b0;
			end else if (in_byte == CH_NL) begin
				// Inside braces a newline is an ordinary kept byte.
				if (depth_zero) begin
					if (seen_q) begin
						res_kind = END_COMPLETE;
						clr      = 1'b1;
					end else begin
						res_vld = 1'b0;
					end
				end
			end else if (in_byte != CH_SPACE && in_byte != CH_TAB &&
				     in_byte != CH_CR && in_byte != CH_SEMI) begin
				seen_nx = 1'b1;
			end
		end
		if (clr) begin
			depth_nx = '0;
			str_nx   = 1'b0;
			esc_nx   = 1'b0;
			seen_nx  = 1'b0;
			cmt_nx   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			str_q       <= 1'b0;
			esc_q       <= 1'b0;
			seen_q      <= 1'b0;
			cmt_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				depth_q <= depth_nx;
				str_q   <= str_nx;
				esc_q   <= esc_nx;
				seen_q  <= seen_nx;
				cmt_q   <= cmt_nx;
			end
			if (in_acc) begin
				out_valid_q <= res_vld;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && res_vld) begin
			out_byte_q <= res_byte;
			has_byte_q <= res_has;
			end_kind_q <= res_kind;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign has_byte  = has_byte_q;
	assign end_kind  = end_kind_q;

endmodule
`default_nettype wire

// ----- design/bbsf_checker.sv -----
// Port-level assertions for the statement framer and their bind.
`default_nettype none
module bbsf_checker import bbsf_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       end_of_stream,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic       has_byte,
	input wire logic [1:0] end_kind
);

	// A stalled result keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
		$stable(has_byte) && $stable(end_kind))
		else $error("output item changed while stalled");

	// End of stream always yields a result.
	a_eos_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && end_of_stream |=> out_valid)
		else $error("end of stream gave no result");

	a_discard_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_kind == END_DISCARD |-> !has_byte)
		else $error("discard item carries a byte");

	a_complete_nl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_kind == END_COMPLETE && has_byte |-> out_byte == CH_NL)
		else $error("statement end byte is not a newline");

	a_no_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_byte |-> out_byte == 8'h00 && end_kind != END_CONTINUE)
		else $error("empty item is malformed");

endmodule

bind brace_balanced_statement_framer bbsf_checker u_bbsf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.end_of_stream (end_of_stream),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.out_byte      (out_byte),
	.has_byte      (has_byte),
	.end_kind      (end_kind)
);
`default_nettype wire
